/* hdl/pnxf_pkg.sv */
// ----------------------------------------------------------------------------
// pnxf_pkg: shared types and constants for the N-of-X packet filter
// Holds the field widths, register indexes, mode codes and the record that
// travels down the remainder pipeline.
// ----------------------------------------------------------------------------
package pnxf_pkg;

  // Input field widths
  localparam int unsigned SeqW   = 14;
  localparam int unsigned TimeW  = 32;
  // Width of the filter key (time key: 11 seconds bits and 4 subseconds bits)
  localparam int unsigned KeyW   = 15;
  localparam int unsigned SecKeyW = 11;
  localparam int unsigned SubKeyW = 4;
  // Register widths
  localparam int unsigned ModeW  = 2;
  localparam int unsigned GrpW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Stream payload widths (whole bytes)
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  // Filter mode codes
  localparam logic [ModeW-1:0] ModeSeq  = 2'd1;
  localparam logic [ModeW-1:0] ModeTime = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPass   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSize   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOffset = 2'd3;

  // Register reset values
  localparam logic [ModeW-1:0] ModeRst   = ModeSeq;
  localparam logic [GrpW-1:0]  PassRst   = 16'd1;
  localparam logic [GrpW-1:0]  SizeRst   = 16'd1;
  localparam logic [GrpW-1:0]  OffsetRst = 16'd0;

  // One item in flight through the remainder pipeline
  typedef struct packed {
    logic            bad;  // drop regardless of the remainder
    logic [KeyW-1:0] dvd;  // dividend bits not yet consumed, MSB first
    logic [GrpW-1:0] rem;  // partial remainder, below group size when size is nonzero
  } stage_t;

endpackage

/* hdl/pnxf_key_stage.sv */
// ----------------------------------------------------------------------------
// pnxf_key_stage: key extraction stage
// Forms the key from the packet, subtracts the group offset and flags
// packets that cannot pass; registers the result with a one-deep handshake.
// ----------------------------------------------------------------------------
module pnxf_key_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pnxf_pkg::ModeW-1:0]   mode_i,
  input  logic [pnxf_pkg::GrpW-1:0]    offset_i,
  input  logic                         cfg_bad_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [pnxf_pkg::SeqW-1:0]    seq_count_i,
  input  logic [pnxf_pkg::TimeW-1:0]   time_seconds_i,
  input  logic [pnxf_pkg::TimeW-1:0]   time_subseconds_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output pnxf_pkg::stage_t             data_o
);
  import pnxf_pkg::*;

  logic [KeyW-1:0] key;
  logic            below;
  stage_t          data_d, data_q;
  logic            valid_q;

  // Select the key source
  always_comb begin
    if (mode_i == ModeSeq) begin
      key = {1'b0, seq_count_i};
    end else begin
      key = {time_seconds_i[SecKeyW-1:0], time_subseconds_i[TimeW-1 -: SubKeyW]};
    end
  end

  // Key below offset drops; otherwise the offset fits in the key width
  assign below = ({1'b0, key} < offset_i);

  always_comb begin
    data_d.bad = cfg_bad_i | below;
    data_d.dvd = key - offset_i[KeyW-1:0];
    data_d.rem = '0;
  end

  assign ready_o = !valid_q || ready_i;

  // Advance when the next stage takes the held item or this one is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/pnxf_div_stage.sv */
// ----------------------------------------------------------------------------
// pnxf_div_stage: one step of the restoring remainder
// Shifts in the next dividend bit, subtracts the group size when it fits,
// and registers the partial result with a one-deep handshake.
// ----------------------------------------------------------------------------
module pnxf_div_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [pnxf_pkg::GrpW-1:0] size_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  pnxf_pkg::stage_t          data_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output pnxf_pkg::stage_t          data_o
);
  import pnxf_pkg::*;

  logic [GrpW:0] shifted;
  logic [GrpW:0] trial;
  stage_t        data_d, data_q;
  logic          valid_q;

  // Bring down one dividend bit and try the subtraction
  assign shifted = {data_i.rem, data_i.dvd[KeyW-1]};
  assign trial   = shifted - {1'b0, size_i};

  always_comb begin
    data_d.bad = data_i.bad;
    data_d.dvd = {data_i.dvd[KeyW-2:0], 1'b0};
    if (shifted >= {1'b0, size_i}) begin
      data_d.rem = trial[GrpW-1:0];
    end else begin
      data_d.rem = shifted[GrpW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/packet_n_of_x_filter_top.sv */
// ----------------------------------------------------------------------------
// packet_n_of_x_filter_top: N-of-X packet decimation filter with offset
// Decides per packet whether to drop it, from a sequence or time key, the
// group size, the pass count and the group offset.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata: seq_count[13:0], time_seconds[45:14],
//            |           |        time_subseconds[77:46]
//  m_axis    | out       | tdata: drop[0]
//  cfg       | in        | write enable, register index, 16-bit data
//
// One packet is accepted per cycle unless a stall on m_axis has backed up to the
// input; its decision passes through 17 register stages: one key stage, 15
// remainder stages (one per key bit) and the output stage.
// Each stage has its own valid bit and ready, so bubbles collapse and a
// stall on m_axis backs up stage by stage without losing an item.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module packet_n_of_x_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [pnxf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pnxf_pkg::GrpW-1:0]      cfg_wdata_i,
  // Packet stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pnxf_pkg::InDataW-1:0]   s_axis_tdata,  // seq_count, time_seconds,
                                                        // time_subseconds, zero pad
  // Decision stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pnxf_pkg::OutDataW-1:0]  m_axis_tdata   // drop, zero pad
);
  import pnxf_pkg::*;

  logic [ModeW-1:0] mode_q;
  logic [GrpW-1:0]  pass_q, size_q, offset_q;
  logic             cfg_bad;

  stage_t st_data  [0:KeyW];
  logic   st_valid [0:KeyW];
  logic   st_ready [0:KeyW];

  logic   out_valid_q;
  logic   drop_q;
  logic   drop_d;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeRst;
      pass_q   <= PassRst;
      size_q   <= SizeRst;
      offset_q <= OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:   mode_q   <= cfg_wdata_i[ModeW-1:0];
        RegPass:   pass_q   <= cfg_wdata_i;
        RegSize:   size_q   <= cfg_wdata_i;
        RegOffset: offset_q <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  // Settings that drop every packet
  assign cfg_bad = (size_q == '0) || (pass_q == '0) || (pass_q > size_q) ||
                   (offset_q >= size_q) || !(mode_q inside {ModeSeq, ModeTime});

  // Key stage
  pnxf_key_stage u_key (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_q),
    .offset_i          (offset_q),
    .cfg_bad_i         (cfg_bad),
    .valid_i           (s_axis_tvalid),
    .ready_o           (s_axis_tready),
    .seq_count_i       (s_axis_tdata[SeqW-1:0]),
    .time_seconds_i    (s_axis_tdata[SeqW +: TimeW]),
    .time_subseconds_i (s_axis_tdata[SeqW+TimeW +: TimeW]),
    .valid_o           (st_valid[0]),
    .ready_i           (st_ready[0]),
    .data_o            (st_data[0])
  );

  // Remainder pipeline, one key bit per stage
  for (genvar i = 0; i < KeyW; i++) begin : g_div
    pnxf_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .size_i  (size_q),
      .valid_i (st_valid[i]),
      .ready_o (st_ready[i]),
      .data_i  (st_data[i]),
      .valid_o (st_valid[i+1]),
      .ready_i (st_ready[i+1]),
      .data_o  (st_data[i+1])
    );
  end

  // Output stage: compare the remainder with the pass count
  assign drop_d         = st_data[KeyW].bad || (st_data[KeyW].rem >= pass_q);
  assign st_ready[KeyW] = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_ready[KeyW]) begin
      out_valid_q <= st_valid[KeyW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready[KeyW] && st_valid[KeyW]) begin
      drop_q <= drop_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, drop_q};

  // A passed packet implies usable settings
  a_pass_needs_good_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> !cfg_bad)
    else $error("packet passed with unusable settings");

  // Input backpressure only comes from a stalled full output
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // Final remainder stays below the group size for good items
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_valid[KeyW] && !st_data[KeyW].bad) |-> (st_data[KeyW].rem < size_q))
    else $error("remainder out of range");

endmodule

/* tb/sv/tb_packet_n_of_x_filter_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_n_of_x_filter_top: regression for the N-of-X packet filter
// Streams packets through the filter under a series of register settings.
// A behavioral decision model runs beside the block and predicts the drop
// flag of every packet taken on s_axis. Each decision leaving m_axis is
// compared in order with that prediction. Sender gaps and receiver stalls
// are varied between phases.
// ----------------------------------------------------------------------------
module tb_packet_n_of_x_filter_top;
  import pnxf_pkg::*;

  // Mode codes that select no key: every packet is dropped
  localparam logic [ModeW-1:0] ModeOffLo = 2'd0;
  localparam logic [ModeW-1:0] ModeOffHi = 2'd3;
  localparam int unsigned      SeqKeyMax  = 16383;
  localparam int unsigned      TimeKeyMax = 32767;
  localparam int unsigned      StallLimit = 4000;
  localparam int unsigned      ReportCap  = 100;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_idx_i;
  logic [GrpW-1:0]       cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;  // seq_count, time_seconds, time_subseconds, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;  // drop, pad

  packet_n_of_x_filter_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the filter registers
  logic [ModeW-1:0] mode_q   = ModeRst;
  logic [GrpW-1:0]  pass_q   = PassRst;
  logic [GrpW-1:0]  size_q   = SizeRst;
  logic [GrpW-1:0]  offset_q = OffsetRst;

  logic [InDataW-1:0] pkt_backlog[$];
  logic               drop_due[$];
  logic               in_fire = 1'b0;
  int unsigned        pkts_sent = 0;
  int unsigned        pkts_taken = 0;
  int unsigned        decisions_seen = 0;
  int unsigned        passed_seen = 0;
  int unsigned        mismatches = 0;
  int unsigned        settings_used = 0;
  int unsigned        quiet_cycles = 0;
  int                 idle_pct = 0;
  int                 stall_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Drop decision for one packet under the shadow registers
  function automatic logic decide_drop(logic [InDataW-1:0] pkt);
    logic [SeqW-1:0]  seq;
    logic [TimeW-1:0] sec;
    logic [TimeW-1:0] sub;
    int unsigned      key;
    seq = pkt[SeqW-1:0];
    sec = pkt[SeqW +: TimeW];
    sub = pkt[SeqW+TimeW +: TimeW];
    if (size_q == 0 || pass_q == 0 || pass_q > size_q || offset_q >= size_q) begin
      return 1'b1;
    end
    if (mode_q == ModeSeq) begin
      key = seq;
    end else if (mode_q == ModeTime) begin
      key = {sec[SecKeyW-1:0], sub[TimeW-1 -: SubKeyW]};
    end else begin
      return 1'b1;
    end
    if (key < offset_q) begin
      return 1'b1;
    end
    return ((key - offset_q) % size_q) >= pass_q;
  endfunction

  // Driver: present the next packet once the previous one is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pkt_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pkt_backlog.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        drop_due.push_back(decide_drop(s_axis_tdata));
        pkts_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        decisions_seen++;
        if (m_axis_tdata[0] == 1'b0) passed_seen++;
        if (drop_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap)
            $display("%0t: unexpected decision, expected none, actual 0x%02h",
                     $time, m_axis_tdata);
        end else begin
          logic exp_drop;
          exp_drop = drop_due.pop_front();
          if (m_axis_tdata != OutDataW'(exp_drop)) begin
            mismatches++;
            if (mismatches <= ReportCap)
              $display("%0t: decision mismatch, expected 0x%02h, actual 0x%02h",
                       $time, OutDataW'(exp_drop), m_axis_tdata);
          end
        end
      end
      // Watchdog: count cycles with no transaction on either side
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, StallLimit);
        $display("packet_n_of_x_filter_top regression: fail");
        $finish;
      end
    end
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  task automatic queue_pkt(logic [SeqW-1:0] seq, logic [TimeW-1:0] sec,
                           logic [TimeW-1:0] sub);
    pkt_backlog.push_back({2'b00, sub, sec, seq});
    pkts_sent++;
  endtask

  // Wait until every packet sent has its decision back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pkts_taken != pkts_sent || drop_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GrpW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegMode:   mode_q   = data[ModeW-1:0];
      RegPass:   pass_q   = data;
      RegSize:   size_q   = data;
      RegOffset: offset_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load all four registers once the pipeline is empty
  task automatic apply_setting(logic [ModeW-1:0] mode, logic [GrpW-1:0] pass,
                               logic [GrpW-1:0] size, logic [GrpW-1:0] offset);
    wait_drained();
    // upper mode bits are junk the block must ignore
    write_reg(RegMode, {14'($urandom), mode});
    write_reg(RegPass, pass);
    write_reg(RegSize, size);
    write_reg(RegOffset, offset);
    repeat (2) @(negedge clk_i);
    settings_used++;
  endtask

  task automatic random_setting();
    int unsigned      sz;
    int unsigned      ps;
    int unsigned      off;
    logic [ModeW-1:0] md;
    md = $urandom_range(1) ? ModeTime : ModeSeq;
    sz = $urandom_range(40, 1);
    ps = $urandom_range(sz, 1);
    off = $urandom_range(sz - 1);
    case ($urandom_range(9))
      0: begin
        sz  = $urandom_range(65535, 16384);
        ps  = $urandom_range(sz, 1);
        off = $urandom_range(2000);
      end
      1: begin
        // broken setting: everything is dropped
        case ($urandom_range(4))
          0: sz = 0;
          1: ps = 0;
          2: ps = sz + $urandom_range(3, 1);
          3: off = sz + $urandom_range(3);
          default: md = $urandom_range(1) ? ModeOffLo : ModeOffHi;
        endcase
      end
      default: ;
    endcase
    apply_setting(md, GrpW'(ps), GrpW'(sz), GrpW'(off));
  endtask

  // Random packet, often with a key placed on a group or pass boundary
  task automatic queue_random_pkt();
    int unsigned      key;
    int unsigned      key_max;
    int unsigned      base;
    logic [SeqW-1:0]  seq;
    logic [TimeW-1:0] sec;
    logic [TimeW-1:0] sub;
    seq = SeqW'($urandom);
    sec = $urandom;
    sub = $urandom;
    key_max = (mode_q == ModeTime) ? TimeKeyMax : SeqKeyMax;
    if ($urandom_range(1) && size_q != 0) begin
      base = offset_q + size_q * $urandom_range(8);
      case ($urandom_range(4))
        0: key = base + pass_q - 1;
        1: key = base + pass_q;
        2: key = base;
        3: key = base + size_q - 1;
        default: key = (base > 0) ? base - 1 : 0;
      endcase
      if (key <= key_max) begin
        if (mode_q == ModeTime) begin
          sec[SecKeyW-1:0]         = key[KeyW-1:SubKeyW];
          sub[TimeW-1 -: SubKeyW] = key[SubKeyW-1:0];
        end else begin
          seq = key[SeqW-1:0];
        end
      end
    end
    queue_pkt(seq, sec, sub);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegMode;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: group of one, every packet passes
    queue_pkt(14'd0, 32'd0, 32'd0);
    queue_pkt(14'h3FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Sequence key, keys below offset and around the pass boundary
    apply_setting(ModeSeq, 16'd3, 16'd7, 16'd2);
    queue_pkt(14'd0, $urandom, $urandom);
    queue_pkt(14'd1, $urandom, $urandom);
    queue_pkt(14'd2, $urandom, $urandom);
    queue_pkt(14'd4, $urandom, $urandom);
    queue_pkt(14'd5, $urandom, $urandom);
    queue_pkt(14'd8, $urandom, $urandom);
    queue_pkt(14'd9, $urandom, $urandom);
    queue_pkt(14'h3FFF, $urandom, $urandom);

    // Time key built from seconds and subseconds extremes
    apply_setting(ModeTime, 16'd5, 16'd16, 16'd3);
    queue_pkt(14'h3FFF, 32'd0, 32'd0);
    queue_pkt(14'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_pkt(14'd0, 32'h0000_0800, 32'h3000_0000);
    queue_pkt(14'd0, 32'h0000_0001, 32'h0FFF_FFFF);
    queue_pkt(14'd0, 32'hFFFF_F7FF, 32'hF000_0000);

    // Broken settings: zero size, zero pass, pass above size, offset at size,
    // and both modes without a key
    apply_setting(ModeSeq, 16'd1, 16'd0, 16'd0);
    queue_pkt(14'd0, 32'd0, 32'd0);
    apply_setting(ModeSeq, 16'd0, 16'd4, 16'd0);
    queue_pkt(14'd0, 32'd0, 32'd0);
    apply_setting(ModeSeq, 16'd5, 16'd4, 16'd0);
    queue_pkt(14'd4, 32'd0, 32'd0);
    apply_setting(ModeTime, 16'd2, 16'd4, 16'd4);
    queue_pkt(14'd4, 32'd1, 32'd0);
    apply_setting(ModeOffLo, 16'd1, 16'd1, 16'd0);
    queue_pkt(14'd0, 32'd0, 32'd0);
    apply_setting(ModeOffHi, 16'd1, 16'd1, 16'd0);
    queue_pkt(14'd0, 32'd0, 32'd0);

    // Register extremes
    apply_setting(ModeSeq, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_pkt(14'h3FFF, 32'd0, 32'd0);
    apply_setting(ModeSeq, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    queue_pkt(14'h3FFF, 32'd0, 32'd0);
    apply_setting(ModeTime, 16'd1, 16'hFFFF, 16'd0);
    queue_pkt(14'd0, 32'hFFFF_F800, 32'h0FFF_FFFF);

    // Random phases; rotate through the sender and receiver pressure modes
    for (int round = 0; round < 16; round++) begin
      random_setting();
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      for (int n = 0; n < 58; n++) queue_random_pkt();
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    $display("Covered %0d packets under %0d register settings.",
             pkts_sent, settings_used + 1);
    $display("Checked %0d decisions: %0d passed, %0d dropped, %0d mismatches.",
             decisions_seen, passed_seen, decisions_seen - passed_seen, mismatches);
    if (mismatches == 0 && drop_due.size() == 0) begin
      $display("packet_n_of_x_filter_top regression: pass");
    end else begin
      $display("packet_n_of_x_filter_top regression: fail");
    end
    $finish;
  end

endmodule
